// File: rtl/calsa_pkg.sv
// shared types, constants and prototype table for the structural alphabet classifier
package calsa_pkg;

    // result field widths
    localparam int LETTER_W = 5;
    localparam int POS_W    = 12;

    // feature format (signed Q8.8)
    localparam int FEAT_W   = 16;
    localparam int FEAT_MAX = 32767;

    // shared multiplier operand width and product width
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // square root unit widths
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 33;
    localparam int LEN_W  = 32;

    // plane distance divider dividend width
    localparam int DIV_W = 52;

    // cross product component width
    localparam int NRM_W = 33;

    // sequencer counter width and vector size
    localparam int CNT_W = 7;
    localparam int AXES  = 3;
    localparam int CROSS_TERMS = 6;

    // prototype table
    localparam int PROTO_ROWS = 27;
    localparam int PROTO_COLS = 4;

    localparam logic signed [FEAT_W-1:0] PROTO [PROTO_ROWS][PROTO_COLS] = '{
        '{16'sd1380, 16'sd1303, 16'sd1377, 16'sd748},
        '{16'sd1390, 16'sd1303, 16'sd1388, 16'sd753},
        '{16'sd1385, 16'sd1339, 16'sd1436, 16'sd732},
        '{16'sd1439, 16'sd1344, 16'sd1388, 16'sd735},
        '{16'sd1431, 16'sd1405, 16'sd1480, 16'sd660},
        '{16'sd1382, 16'sd1428, 16'sd1388, 16'sd868},
        '{16'sd1480, 16'sd1454, 16'sd1554, 16'sd374},
        '{16'sd1421, 16'sd1981, 16'sd1434, -16'sd847},
        '{16'sd1434, 16'sd1718, 16'sd1408, 16'sd945},
        '{16'sd1457, 16'sd2071, 16'sd1452, 16'sd791},
        '{16'sd1449, 16'sd2291, 16'sd1674, 16'sd535},
        '{16'sd1449, 16'sd2281, 16'sd1705, -16'sd374},
        '{16'sd1449, 16'sd2066, 16'sd1715, 16'sd758},
        '{16'sd1459, 16'sd1859, 16'sd1797, 16'sd225},
        '{16'sd1544, 16'sd1754, 16'sd1444, -16'sd161},
        '{16'sd1656, 16'sd1516, 16'sd1423, 16'sd136},
        '{16'sd1682, 16'sd2294, 16'sd1428, -16'sd561},
        '{16'sd1718, 16'sd2117, 16'sd1400, -16'sd911},
        '{16'sd1590, 16'sd2358, 16'sd1477, 16'sd69},
        '{16'sd1759, 16'sd2120, 16'sd1544, -16'sd881},
        '{16'sd1764, 16'sd2289, 16'sd1731, -16'sd123},
        '{16'sd1720, 16'sd2335, 16'sd1641, -16'sd847},
        '{16'sd1718, 16'sd2468, 16'sd1664, -16'sd666},
        '{16'sd1636, 16'sd2542, 16'sd1728, -16'sd274},
        '{16'sd1759, 16'sd2575, 16'sd1667, -16'sd361},
        '{16'sd1659, 16'sd2604, 16'sd1815, 16'sd169},
        '{16'sd1741, 16'sd2650, 16'sd1754, -16'sd64}
    };

    // back end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_LEN_SQ,
        ST_LEN_WT,
        ST_PL_MAX,
        ST_PL_SH,
        ST_PL_CR,
        ST_PL_NN,
        ST_PL_SQ,
        ST_PL_SQW,
        ST_PL_DOT,
        ST_PL_DVI,
        ST_PL_DIV,
        ST_PL_RES,
        ST_CLS,
        ST_OUT
    } back_state_t;

    // square root unit request and response
    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// File: rtl/calsa_ifs.sv
// point and result channel interfaces
interface calsa_in_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] x_coord;
    logic signed [COORD_WIDTH-1:0] y_coord;
    logic signed [COORD_WIDTH-1:0] z_coord;
    logic                          present;
    logic                          chain_start;

    modport source (output valid, x_coord, y_coord, z_coord, present, chain_start,
                    input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, present, chain_start,
                    output ready);
endinterface

interface calsa_out_if;
    logic                          valid;
    logic                          ready;
    logic [calsa_pkg::LETTER_W-1:0] letter;
    logic [calsa_pkg::POS_W-1:0]    position;

    modport source (output valid, letter, position, input ready);
    modport sink   (input valid, letter, position, output ready);
endinterface

// File: rtl/calsa_queue.sv
// two entry request queue between front and back end
module calsa_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output logic [W-1:0] pop_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;
    logic         push_fire, pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid & push_ready;
    assign pop_fire   = pop_valid & pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push_fire ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_fire ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/calsa_front.sv
// front end: point window, emission check and difference vectors
module calsa_front #(
    parameter int COORD_WIDTH  = 24,
    parameter int MAX_RESIDUES = 4096,
    parameter int ENT_W        = 12 * (COORD_WIDTH + 1) + calsa_pkg::POS_W
) (
    input  logic             clk,
    input  logic             rst_n,
    calsa_in_if.sink         point,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [ENT_W-1:0] push_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = COORD_WIDTH + 1;
    localparam int CNT_W = $clog2(MAX_RESIDUES);
    localparam int PW    = calsa_pkg::POS_W;

    logic signed [CW-1:0] wx_reg [3];
    logic signed [CW-1:0] wy_reg [3];
    logic signed [CW-1:0] wz_reg [3];
    logic [2:0]           wv_reg, wv_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 accept;
    logic [2:0]           wv_eff;
    logic                 emit;
    logic [CNT_W-1:0]     idx;
    logic [CNT_W+PW-1:0]  idx_ext;

    logic signed [DW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz;

    assign accept      = point.valid & point.ready;
    assign point.ready = push_ready;

    // window state as seen by this point
    assign wv_eff  = point.chain_start ? 3'b000 : wv_reg;
    assign emit    = point.present & (&wv_eff);
    assign idx     = point.chain_start ? '0 : count_reg;
    assign idx_ext = {{PW{1'b0}}, idx};

    // sign extended corners
    assign ax = $signed({wx_reg[0][CW-1], wx_reg[0]});
    assign ay = $signed({wy_reg[0][CW-1], wy_reg[0]});
    assign az = $signed({wz_reg[0][CW-1], wz_reg[0]});
    assign bx = $signed({wx_reg[1][CW-1], wx_reg[1]});
    assign by = $signed({wy_reg[1][CW-1], wy_reg[1]});
    assign bz = $signed({wz_reg[1][CW-1], wz_reg[1]});
    assign cx = $signed({wx_reg[2][CW-1], wx_reg[2]});
    assign cy = $signed({wy_reg[2][CW-1], wy_reg[2]});
    assign cz = $signed({wz_reg[2][CW-1], wz_reg[2]});
    assign dx = $signed({point.x_coord[CW-1], point.x_coord});
    assign dy = $signed({point.y_coord[CW-1], point.y_coord});
    assign dz = $signed({point.z_coord[CW-1], point.z_coord});

    // request: u = b-a, v = c-a, w = d-a, x = d-b, position
    assign push_valid = point.valid & emit;
    assign push_data  = {bx - ax, by - ay, bz - az,
                         cx - ax, cy - ay, cz - az,
                         dx - ax, dy - ay, dz - az,
                         dx - bx, dy - by, dz - bz,
                         idx_ext[PW-1:0]};

    // window valid flags and saturating position count
    always_comb
    begin
        wv_next    = wv_reg;
        count_next = count_reg;
        if (accept)
        begin
            wv_next = {point.present, wv_eff[2:1]};
            if (idx < CNT_W'(MAX_RESIDUES - 1))
            begin
                count_next = idx + 1'b1;
            end
            else
            begin
                count_next = CNT_W'(MAX_RESIDUES - 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg    <= 3'b000;
            count_reg <= '0;
        end
        else
        begin
            wv_reg    <= wv_next;
            count_reg <= count_next;
        end
    end

    // point window shift
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wx_reg[0] <= wx_reg[1];
            wy_reg[0] <= wy_reg[1];
            wz_reg[0] <= wz_reg[1];
            wx_reg[1] <= wx_reg[2];
            wy_reg[1] <= wy_reg[2];
            wz_reg[1] <= wz_reg[2];
            wx_reg[2] <= point.x_coord;
            wy_reg[2] <= point.y_coord;
            wz_reg[2] <= point.z_coord;
        end
    end

endmodule

// File: rtl/calsa_sqrt.sv
// iterative rounded square root, two radicand bits per cycle
module calsa_sqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  calsa_pkg::sqrt_req_t req,
    output calsa_pkg::sqrt_rsp_t rsp
);

    localparam int RW = calsa_pkg::RAD_W;

    logic          busy_reg, busy_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] root_reg, root_next;
    logic [RW-1:0] bit_reg, bit_next;
    logic [RW-1:0] trial;
    logic          finish;

    assign trial  = root_reg + bit_reg;
    assign finish = busy_reg & (bit_reg == '0);

    // rounded result: bump when remainder exceeds the root
    assign rsp.done = finish;
    assign rsp.root = (rem_reg > root_reg) ? (root_reg[calsa_pkg::ROOT_W-1:0] + 1'b1)
                                           : root_reg[calsa_pkg::ROOT_W-1:0];

    // digit recurrence
    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            rem_next  = req.radicand;
            root_next = '0;
            bit_next  = RW'(1) << (RW - 2);
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

endmodule

// File: rtl/calsa_back.sv
// back end: feature sequencer with shared multiplier, divider and prototype scan
module calsa_back #(
    parameter int COORD_WIDTH    = 24,
    parameter int NUM_PROTOTYPES = 27,
    parameter int ENT_W          = 12 * (COORD_WIDTH + 1) + calsa_pkg::POS_W
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  logic [ENT_W-1:0]      pop_data,
    output calsa_pkg::sqrt_req_t  sq_req,
    input  calsa_pkg::sqrt_rsp_t  sq_rsp,
    calsa_out_if.source           result
);

    localparam int DW    = COORD_WIDTH + 1;
    localparam int SW    = $clog2(DW);
    localparam int FW    = calsa_pkg::FEAT_W;
    localparam int MW    = calsa_pkg::MUL_W;
    localparam int PW    = calsa_pkg::PROD_W;
    localparam int NW    = calsa_pkg::NRM_W;
    localparam int CW    = calsa_pkg::CNT_W;
    localparam int LW    = calsa_pkg::LEN_W;
    localparam int QW    = calsa_pkg::DIV_W;
    localparam int NROW  = (NUM_PROTOTYPES < calsa_pkg::PROTO_ROWS) ?
                           NUM_PROTOTYPES : calsa_pkg::PROTO_ROWS;
    localparam int CLS_N = NROW * calsa_pkg::PROTO_COLS;

    typedef struct packed {
        logic signed [DW-1:0] ux, uy, uz;
        logic signed [DW-1:0] vx, vy, vz;
        logic signed [DW-1:0] wx, wy, wz;
        logic signed [DW-1:0] xx, xy, xz;
        logic [calsa_pkg::POS_W-1:0] pos;
    } ent_t;

    function automatic logic [DW-1:0] mag_f(input logic signed [DW-1:0] x);
        logic [DW-1:0] t;
        t     = x;
        mag_f = x[DW-1] ? (~t + 1'b1) : t;
    endfunction

    calsa_pkg::back_state_t state_reg, state_next;

    ent_t                 ent_reg, ent_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [1:0]           li_reg, li_next;
    logic signed [FW-1:0] feat_reg [4];
    logic signed [FW-1:0] feat_next [4];
    logic [DW-1:0]        m_reg, m_next;
    logic [SW-1:0]        s_reg, s_next;
    logic signed [FW-1:0] su_reg [3], sv_reg [3], sw_reg [3];
    logic signed [FW-1:0] su_next [3], sv_next [3], sw_next [3];
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] n_next [3];
    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [LW-1:0]        len_reg, len_next;
    logic [QW-1:0]        dq_reg, dq_next;
    logic [LW-1:0]        drem_reg, drem_next;
    logic                 dneg_reg, dneg_next;
    logic [PW-1:0]        best_reg, best_next;
    logic [calsa_pkg::LETTER_W-1:0] let_reg, let_next;
    logic                 ov_reg, ov_next;
    logic [calsa_pkg::LETTER_W-1:0] out_let_reg, out_let_next;
    logic [calsa_pkg::POS_W-1:0]    out_pos_reg, out_pos_next;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [DW-1:0] lv [3];
    logic                 lsat;
    logic [CW-1:0]        t;
    logic [1:0]           tk;
    logic [4:0]           tj;
    logic [1:0]           ik;
    logic [4:0]           ij;
    logic signed [FW:0]   e;
    logic signed [PW-1:0] sum, dif;
    logic [DW-1:0]        mg [9];
    logic [DW-1:0]        mmax;
    logic [PW-1:0]        amag;
    logic [LW:0]          rsh;
    logic [16:0]          lim;
    logic [16:0]          qs;
    logic signed [16:0]   qneg;
    logic                 qsat;
    logic                 out_free;

    assign pop_ready     = (state_reg == calsa_pkg::ST_IDLE);
    assign result.valid    = ov_reg;
    assign result.letter   = out_let_reg;
    assign result.position = out_pos_reg;
    assign out_free = !ov_reg || result.ready;

    assign sq_req.start    = (state_reg == calsa_pkg::ST_LEN_SQ) ||
                             (state_reg == calsa_pkg::ST_PL_SQ);
    assign sq_req.radicand = acc_reg[calsa_pkg::RAD_W-1:0];

    // product index consumed this cycle and index issued this cycle
    assign t  = cnt_reg - 1'b1;
    assign tk = t[1:0];
    assign tj = t[6:2];
    assign ik = cnt_reg[1:0];
    assign ij = cnt_reg[6:2];

    // length vector under work
    always_comb
    begin
        case (li_reg)
            2'd0:    begin lv[0] = ent_reg.vx; lv[1] = ent_reg.vy; lv[2] = ent_reg.vz; end
            2'd1:    begin lv[0] = ent_reg.wx; lv[1] = ent_reg.wy; lv[2] = ent_reg.wz; end
            default: begin lv[0] = ent_reg.xx; lv[1] = ent_reg.xy; lv[2] = ent_reg.xz; end
        endcase
        lsat = (mag_f(lv[0]) > DW'(calsa_pkg::FEAT_MAX)) ||
               (mag_f(lv[1]) > DW'(calsa_pkg::FEAT_MAX)) ||
               (mag_f(lv[2]) > DW'(calsa_pkg::FEAT_MAX));
    end

    // largest component magnitude of u, v, w
    always_comb
    begin
        mg[0] = mag_f(ent_reg.ux); mg[1] = mag_f(ent_reg.uy); mg[2] = mag_f(ent_reg.uz);
        mg[3] = mag_f(ent_reg.vx); mg[4] = mag_f(ent_reg.vy); mg[5] = mag_f(ent_reg.vz);
        mg[6] = mag_f(ent_reg.wx); mg[7] = mag_f(ent_reg.wy); mg[8] = mag_f(ent_reg.wz);
        mmax = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (mg[i] > mmax)
            begin
                mmax = mg[i];
            end
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        e     = '0;
        case (state_reg)
            calsa_pkg::ST_LEN:
            begin
                if (cnt_reg < CW'(calsa_pkg::AXES))
                begin
                    mul_a = {{(MW-FW){lv[ik][FW-1]}}, lv[ik][FW-1:0]};
                    mul_b = mul_a;
                end
            end
            calsa_pkg::ST_PL_CR:
            begin
                case (cnt_reg[2:0])
                    3'd0:    begin mul_a = MW'(su_reg[1]); mul_b = MW'(sv_reg[2]); end
                    3'd1:    begin mul_a = MW'(su_reg[2]); mul_b = MW'(sv_reg[1]); end
                    3'd2:    begin mul_a = MW'(su_reg[2]); mul_b = MW'(sv_reg[0]); end
                    3'd3:    begin mul_a = MW'(su_reg[0]); mul_b = MW'(sv_reg[2]); end
                    3'd4:    begin mul_a = MW'(su_reg[0]); mul_b = MW'(sv_reg[1]); end
                    3'd5:    begin mul_a = MW'(su_reg[1]); mul_b = MW'(sv_reg[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            calsa_pkg::ST_PL_NN:
            begin
                if (cnt_reg < CW'(calsa_pkg::AXES))
                begin
                    mul_a = MW'(n_reg[ik]);
                    mul_b = mul_a;
                end
            end
            calsa_pkg::ST_PL_DOT:
            begin
                if (cnt_reg < CW'(calsa_pkg::AXES))
                begin
                    mul_a = MW'(n_reg[ik]);
                    mul_b = MW'(sw_reg[ik]);
                end
            end
            calsa_pkg::ST_CLS:
            begin
                if (cnt_reg < CW'(CLS_N))
                begin
                    e = $signed({feat_reg[ik][FW-1], feat_reg[ik]}) -
                        $signed({calsa_pkg::PROTO[ij][ik][FW-1], calsa_pkg::PROTO[ij][ik]});
                    mul_a = MW'(e);
                    mul_b = mul_a;
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign sum       = acc_reg + prod_reg;
    assign dif       = acc_reg - prod_reg;
    assign amag      = acc_reg[PW-1] ? (~acc_reg + 1'b1) : acc_reg;
    assign rsh       = {drem_reg, dq_reg[QW-1]};

    // plane distance rescale and saturation
    always_comb
    begin
        lim  = dneg_reg ? (17'd32768 >> s_reg) : (17'd32767 >> s_reg);
        qsat = dq_reg > QW'(lim);
        qs   = dq_reg[16:0] << s_reg;
        qneg = -$signed(qs);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            calsa_pkg::ST_IDLE:
                if (pop_valid) state_next = calsa_pkg::ST_LEN;
            calsa_pkg::ST_LEN:
            begin
                if (lsat)
                begin
                    if (li_reg == 2'd2) state_next = calsa_pkg::ST_PL_MAX;
                end
                else if (cnt_reg == CW'(calsa_pkg::AXES))
                begin
                    state_next = calsa_pkg::ST_LEN_SQ;
                end
            end
            calsa_pkg::ST_LEN_SQ:
                state_next = calsa_pkg::ST_LEN_WT;
            calsa_pkg::ST_LEN_WT:
                if (sq_rsp.done)
                    state_next = (li_reg == 2'd2) ? calsa_pkg::ST_PL_MAX : calsa_pkg::ST_LEN;
            calsa_pkg::ST_PL_MAX:
                state_next = calsa_pkg::ST_PL_SH;
            calsa_pkg::ST_PL_SH:
                if (m_reg <= DW'(calsa_pkg::FEAT_MAX)) state_next = calsa_pkg::ST_PL_CR;
            calsa_pkg::ST_PL_CR:
                if (cnt_reg == CW'(calsa_pkg::CROSS_TERMS)) state_next = calsa_pkg::ST_PL_NN;
            calsa_pkg::ST_PL_NN:
                if (cnt_reg == CW'(calsa_pkg::AXES)) state_next = calsa_pkg::ST_PL_SQ;
            calsa_pkg::ST_PL_SQ:
                state_next = calsa_pkg::ST_PL_SQW;
            calsa_pkg::ST_PL_SQW:
                if (sq_rsp.done)
                    state_next = (sq_rsp.root == '0) ? calsa_pkg::ST_OUT : calsa_pkg::ST_PL_DOT;
            calsa_pkg::ST_PL_DOT:
                if (cnt_reg == CW'(calsa_pkg::AXES)) state_next = calsa_pkg::ST_PL_DVI;
            calsa_pkg::ST_PL_DVI:
                state_next = calsa_pkg::ST_PL_DIV;
            calsa_pkg::ST_PL_DIV:
                if (cnt_reg == CW'(QW - 1)) state_next = calsa_pkg::ST_PL_RES;
            calsa_pkg::ST_PL_RES:
                state_next = calsa_pkg::ST_CLS;
            calsa_pkg::ST_CLS:
                if (cnt_reg == CW'(CLS_N)) state_next = calsa_pkg::ST_OUT;
            calsa_pkg::ST_OUT:
                if (out_free) state_next = calsa_pkg::ST_IDLE;
            default:
                state_next = calsa_pkg::ST_IDLE;
        endcase
    end

    // datapath updates
    always_comb
    begin
        ent_next     = ent_reg;
        cnt_next     = (state_next != state_reg) ? '0 : cnt_reg + 1'b1;
        li_next      = li_reg;
        feat_next    = feat_reg;
        m_next       = m_reg;
        s_next       = s_reg;
        su_next      = su_reg;
        sv_next      = sv_reg;
        sw_next      = sw_reg;
        n_next       = n_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        dq_next      = dq_reg;
        drem_next    = drem_reg;
        dneg_next    = dneg_reg;
        best_next    = best_reg;
        let_next     = let_reg;
        ov_next      = ov_reg & ~result.ready;
        out_let_next = out_let_reg;
        out_pos_next = out_pos_reg;
        case (state_reg)
            calsa_pkg::ST_IDLE:
            begin
                ent_next = ent_t'(pop_data);
                li_next  = 2'd0;
                let_next = '0;
            end
            calsa_pkg::ST_LEN:
            begin
                if (lsat)
                begin
                    feat_next[li_reg] = FW'(calsa_pkg::FEAT_MAX);
                    li_next           = li_reg + 2'd1;
                    cnt_next          = '0;
                end
                else if (cnt_reg != '0)
                begin
                    acc_next = (tk == 2'd0) ? prod_reg : sum;
                end
            end
            calsa_pkg::ST_LEN_WT:
            begin
                if (sq_rsp.done)
                begin
                    feat_next[li_reg] = (sq_rsp.root > calsa_pkg::ROOT_W'(calsa_pkg::FEAT_MAX))
                                        ? FW'(calsa_pkg::FEAT_MAX) : sq_rsp.root[FW-1:0];
                    li_next = li_reg + 2'd1;
                end
            end
            calsa_pkg::ST_PL_MAX:
            begin
                m_next = mmax;
                s_next = '0;
            end
            calsa_pkg::ST_PL_SH:
            begin
                if (m_reg > DW'(calsa_pkg::FEAT_MAX))
                begin
                    m_next = m_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    su_next[0] = FW'(ent_reg.ux >>> s_reg);
                    su_next[1] = FW'(ent_reg.uy >>> s_reg);
                    su_next[2] = FW'(ent_reg.uz >>> s_reg);
                    sv_next[0] = FW'(ent_reg.vx >>> s_reg);
                    sv_next[1] = FW'(ent_reg.vy >>> s_reg);
                    sv_next[2] = FW'(ent_reg.vz >>> s_reg);
                    sw_next[0] = FW'(ent_reg.wx >>> s_reg);
                    sw_next[1] = FW'(ent_reg.wy >>> s_reg);
                    sw_next[2] = FW'(ent_reg.wz >>> s_reg);
                end
            end
            calsa_pkg::ST_PL_CR:
            begin
                if (cnt_reg != '0)
                begin
                    if (t[0] == 1'b0)
                    begin
                        acc_next = prod_reg;
                    end
                    else
                    begin
                        n_next[t[2:1]] = dif[NW-1:0];
                    end
                end
            end
            calsa_pkg::ST_PL_NN, calsa_pkg::ST_PL_DOT:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = (tk == 2'd0) ? prod_reg : sum;
                end
            end
            calsa_pkg::ST_PL_SQW:
            begin
                if (sq_rsp.done)
                begin
                    len_next = sq_rsp.root[LW-1:0];
                end
            end
            calsa_pkg::ST_PL_DVI:
            begin
                dneg_next = acc_reg[PW-1];
                dq_next   = amag[QW-1:0] + QW'(len_reg >> 1);
                drem_next = '0;
            end
            calsa_pkg::ST_PL_DIV:
            begin
                if (rsh >= {1'b0, len_reg})
                begin
                    drem_next = LW'(rsh - {1'b0, len_reg});
                    dq_next   = {dq_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    drem_next = rsh[LW-1:0];
                    dq_next   = {dq_reg[QW-2:0], 1'b0};
                end
            end
            calsa_pkg::ST_PL_RES:
            begin
                if (qsat)
                begin
                    feat_next[3] = dneg_reg ? FW'(-32768) : FW'(calsa_pkg::FEAT_MAX);
                end
                else
                begin
                    feat_next[3] = dneg_reg ? qneg[FW-1:0] : qs[FW-1:0];
                end
            end
            calsa_pkg::ST_CLS:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = (tk == 2'd0) ? prod_reg : sum;
                    if (tk == 2'd3)
                    begin
                        if ((tj == 5'd0) || (sum < $signed(best_reg)))
                        begin
                            best_next = sum;
                            let_next  = tj;
                        end
                    end
                end
            end
            calsa_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    out_let_next = let_reg;
                    out_pos_next = ent_reg.pos;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= calsa_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            li_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            li_reg    <= li_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ent_reg     <= ent_next;
        feat_reg    <= feat_next;
        m_reg       <= m_next;
        s_reg       <= s_next;
        su_reg      <= su_next;
        sv_reg      <= sv_next;
        sw_reg      <= sw_next;
        n_reg       <= n_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        len_reg     <= len_next;
        dq_reg      <= dq_next;
        drem_reg    <= drem_next;
        dneg_reg    <= dneg_next;
        best_reg    <= best_next;
        let_reg     <= let_next;
        out_let_reg <= out_let_next;
        out_pos_reg <= out_pos_next;
    end

endmodule

// File: rtl/calpha_structural_alphabet_classifier.sv
// top level of the C-alpha structural alphabet classifier
//
// Takes one C-alpha point per request and returns, for each point that closes a window
// of four present points, the index of the nearest of 27 structural prototypes and the
// chain position of that point. A point that gives no result is taken whenever
// the queue has room. A point that gives a result is handed to the back end through a
// two entry queue, so the front keeps taking points while the back works; once both
// queue entries wait, the front holds every point until the back end frees one. For
// each result the back end works out three lengths, each from three squares and then the
// one shared square root unit, one root digit a cycle; it then scales the plane vectors
// down where they are too large, forms the plane normal and its length, takes the plane
// distance through a bit-serial divider, and runs the prototype scan one squared
// difference a cycle through the single shared multiplier. A length that saturates skips
// its root, and a degenerate plane skips the distance and the scan.
module calpha_structural_alphabet_classifier #(
    parameter int MAX_RESIDUES   = 4096,
    parameter int NUM_PROTOTYPES = 27,
    parameter int COORD_WIDTH    = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    calsa_in_if.sink     point,
    calsa_out_if.source  result
);

    localparam int ENT_W = 12 * (COORD_WIDTH + 1) + calsa_pkg::POS_W;

    logic                 push_valid, push_ready;
    logic [ENT_W-1:0]     push_data;
    logic                 pop_valid, pop_ready;
    logic [ENT_W-1:0]     pop_data;
    calsa_pkg::sqrt_req_t sq_req;
    calsa_pkg::sqrt_rsp_t sq_rsp;

    // window and emission check
    calsa_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .MAX_RESIDUES (MAX_RESIDUES),
        .ENT_W        (ENT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    calsa_queue #(
        .W (ENT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // feature and classification sequencer
    calsa_back #(
        .COORD_WIDTH    (COORD_WIDTH),
        .NUM_PROTOTYPES (NUM_PROTOTYPES),
        .ENT_W          (ENT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .sq_req    (sq_req),
        .sq_rsp    (sq_rsp),
        .result    (result)
    );

    // shared square root
    calsa_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

`ifndef SYNTHESIS
    // only present points are queued for classification
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && push_ready) |-> (point.valid && point.ready && point.present))
        else $error("queued request without a present point");

    // letter stays inside the prototype set
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.letter < calsa_pkg::LETTER_W'(calsa_pkg::PROTO_ROWS)))
        else $error("letter out of range");

    // root response lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        sq_rsp.done |=> !sq_rsp.done)
        else $error("square root done held");
`endif

endmodule
